// File: sv/scd_pkg.sv
// shared constants, types and helpers for the statement dependence classifier
// no dependencies; imported by scd_ctrl, scd_dp and statement_dependence_classifier
package scd_pkg;

	localparam int MAX_STMTS = 8;
	localparam int IDX_W     = $clog2(MAX_STMTS);
	localparam int CNT_W     = $clog2(MAX_STMTS + 1);

	localparam int VAR_W     = 6;
	localparam int VAR_SPAN  = 1 << VAR_W;
	localparam int MASK_W    = 52;
	localparam int STMT_W    = 3;
	localparam int REL_W     = 2;

	localparam int IN_DATA_W  = ((VAR_W + MASK_W + 7) / 8) * 8;
	localparam int OUT_BITS   = 2 * STMT_W + REL_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [REL_W-1:0] REL_INDEP  = 2'd0;
	localparam logic [REL_W-1:0] REL_ANTI   = 2'd1;
	localparam logic [REL_W-1:0] REL_FLOW   = 2'd2;
	localparam logic [REL_W-1:0] REL_OUTPUT = 2'd3;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [VAR_W-1:0]  wr_var;
		logic [MASK_W-1:0] wr_mask;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_i;
		logic [IDX_W-1:0]  rd_j;
		logic              rd_last;
		logic              rd_ovf;
	} scd_cmd_t;

	typedef struct packed {
		logic issue_ok;
	} scd_status_t;

	// codes at or above the mask width read as not present
	function automatic logic reads_var(input logic [MASK_W-1:0] mask,
		input logic [VAR_W-1:0] var_code);
		logic [VAR_SPAN-1:0] ext;
		ext = {{(VAR_SPAN - MASK_W){1'b0}}, mask};
		return ext[var_code];
	endfunction

endpackage

// File: sv/scd_ctrl.sv
// controller: statement loading, run bookkeeping and pair sweep sequencing
// depends on scd_pkg; drives scd_dp through scd_cmd_t / scd_status_t
module scd_ctrl
	import scd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [VAR_W-1:0]  in_var,
	input  logic [MASK_W-1:0] in_mask,
	input  logic              in_last,
	input  scd_status_t       status,
	output scd_cmd_t          cmd
);

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_PAIRS = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [CNT_W-1:0] total_q;
	logic             run_ovf_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;

	logic             accept;
	logic             room;
	logic [CNT_W-1:0] count_after;
	logic             ovf_after;
	logic             j_end;
	logic             pair_last;
	logic             issue;

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;
	assign room     = (count_q < CNT_W'(MAX_STMTS));

	assign count_after = room ? count_q + CNT_W'(1) : count_q;
	assign ovf_after   = ovf_q || !room;

	assign j_end     = ({1'b0, j_q} == total_q - CNT_W'(1));
	assign pair_last = j_end && ({1'b0, i_q} == total_q - CNT_W'(2));
	assign issue     = (state_q == ST_PAIRS) && status.issue_ok;

	always_comb begin
		cmd         = '0;
		cmd.wr_en   = accept && room;
		cmd.wr_addr = count_q[IDX_W-1:0];
		cmd.wr_var  = in_var;
		cmd.wr_mask = in_mask;
		cmd.rd_en   = issue;
		cmd.rd_i    = i_q;
		cmd.rd_j    = j_q;
		cmd.rd_last = pair_last;
		cmd.rd_ovf  = run_ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			total_q   <= '0;
			run_ovf_q <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (in_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							if (count_after >= CNT_W'(2)) begin
								state_q   <= ST_PAIRS;
								total_q   <= count_after;
								run_ovf_q <= ovf_after;
								i_q       <= '0;
								j_q       <= IDX_W'(1);
							end
						end else begin
							count_q <= count_after;
							ovf_q   <= ovf_after;
						end
					end
				end
				ST_PAIRS: begin
					if (issue) begin
						if (pair_last) begin
							state_q <= ST_LOAD;
						end else if (j_end) begin
							i_q <= i_q + IDX_W'(1);
							j_q <= i_q + IDX_W'(2);
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIRS) |-> (i_q < j_q))
		else $error("pair sweep index order broken");

	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIRS) |-> ({1'b0, j_q} < total_q && total_q >= CNT_W'(2)))
		else $error("pair sweep beyond stored statements");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && pair_last) |=> (state_q == ST_LOAD))
		else $error("sweep did not end after final pair");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_STMTS))
		else $error("statement count above capacity");
`endif

endmodule

// File: sv/scd_dp.sv
// datapath: statement store, registered pair read, classification, output register
// depends on scd_pkg; commanded by scd_ctrl
module scd_dp
	import scd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  scd_cmd_t          cmd,
	output scd_status_t       status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STMT_W-1:0] out_first,
	output logic [STMT_W-1:0] out_second,
	output logic [REL_W-1:0]  out_rel,
	output logic              out_last,
	output logic              out_ovf
);

	logic [VAR_W-1:0]  var_mem  [MAX_STMTS];
	logic [MASK_W-1:0] mask_mem [MAX_STMTS];

	logic              valid_s1;
	logic [VAR_W-1:0]  var_i_s1;
	logic [VAR_W-1:0]  var_j_s1;
	logic [MASK_W-1:0] mask_i_s1;
	logic [MASK_W-1:0] mask_j_s1;
	logic [IDX_W-1:0]  i_s1;
	logic [IDX_W-1:0]  j_s1;
	logic              last_s1;
	logic              ovf_s1;

	logic              out_valid_q;
	logic [STMT_W-1:0] first_q;
	logic [STMT_W-1:0] second_q;
	logic [REL_W-1:0]  rel_q;
	logic              last_q;
	logic              ovf_q;

	logic              out_free;
	logic [REL_W-1:0]  rel;

	assign out_free        = !out_valid_q || out_ready;
	assign status.issue_ok = !valid_s1 || out_free;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			var_mem[cmd.wr_addr]  <= cmd.wr_var;
			mask_mem[cmd.wr_addr] <= cmd.wr_mask;
		end
		if (cmd.rd_en) begin
			var_i_s1  <= var_mem[cmd.rd_i];
			var_j_s1  <= var_mem[cmd.rd_j];
			mask_i_s1 <= mask_mem[cmd.rd_i];
			mask_j_s1 <= mask_mem[cmd.rd_j];
			i_s1      <= cmd.rd_i;
			j_s1      <= cmd.rd_j;
			last_s1   <= cmd.rd_last;
			ovf_s1    <= cmd.rd_ovf;
		end
	end

	// anti, then flow, then output dependence
	always_comb begin
		if (reads_var(mask_i_s1, var_j_s1)) begin
			rel = REL_ANTI;
		end else if (reads_var(mask_j_s1, var_i_s1)) begin
			rel = REL_FLOW;
		end else if (var_i_s1 == var_j_s1) begin
			rel = REL_OUTPUT;
		end else begin
			rel = REL_INDEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			first_q  <= STMT_W'(i_s1);
			second_q <= STMT_W'(j_s1);
			rel_q    <= rel;
			last_q   <= last_s1;
			ovf_q    <= ovf_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_first  = first_q;
	assign out_second = second_q;
	assign out_rel    = rel_q;
	assign out_last   = last_q;
	assign out_ovf    = ovf_q;

endmodule

// File: sv/statement_dependence_classifier.sv
// Statements load at one beat per cycle; up to MAX_STMTS (8) are kept and any
// beyond that are dropped and reported through the overflow flag. The beat with
// tlast ends the run: for n stored statements the block then emits n(n-1)/2 pair
// results, one per cycle while m_tready stays high, in order of the earlier index
// and then the later one, with the final pair marked by tlast. A pair passes from issue
// through the store read register, then classification into the output register;
// the pair sweep is paced by the store's two read ports and pauses while the output
// register is held. Input tready stays low while the sweep issues pairs, and a run
// with fewer than two stored statements gives no result.
// depends on scd_pkg, scd_ctrl, scd_dp
module statement_dependence_classifier
	import scd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // written_var, read_mask, zero fill
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // first_stmt, second_stmt, relation
	output logic                  m_tlast,
	output logic                  m_tuser   // overflowed
);

	scd_cmd_t          cmd;
	scd_status_t       status;
	logic [STMT_W-1:0] first_stmt;
	logic [STMT_W-1:0] second_stmt;
	logic [REL_W-1:0]  relation;

	scd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_var   (s_tdata[VAR_W-1:0]),
		.in_mask  (s_tdata[VAR_W+MASK_W-1:VAR_W]),
		.in_last  (s_tlast),
		.status   (status),
		.cmd      (cmd)
	);

	scd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_first  (first_stmt),
		.out_second (second_stmt),
		.out_rel    (relation),
		.out_last   (m_tlast),
		.out_ovf    (m_tuser)
	);

	assign m_tdata = OUT_DATA_W'({relation, second_stmt, first_stmt});

endmodule
